>>> sv/rngrt_pkg.sv
// Package for the random number ready timer.
// Holds operation codes, register indexes, transaction structs and the
// countdown load function; no dependencies.
package rngrt_pkg;

  localparam int unsigned FIRST_EXTRA_DELAY = 128;
  localparam int unsigned CORRECTED_DELAY   = 120;
  localparam int unsigned RAW_DELAY         = 30;

  localparam int unsigned CountW  = 8;
  localparam int unsigned ValueW  = 32;
  localparam int unsigned CfgAddrW = 3;
  localparam int unsigned CfgDataW = 32;

  typedef enum logic [2:0] {
    OP_TICK      = 3'd0,
    OP_START     = 3'd1,
    OP_STOP      = 3'd2,
    OP_EN_SET    = 3'd3,
    OP_EN_CLR    = 3'd4,
    OP_EVT_WRITE = 3'd5
  } op_t;

  typedef enum logic {
    REG_BIAS_CORRECTION = 1'b0,
    REG_STOP_ON_READY   = 1'b1
  } reg_idx_t;

  typedef struct packed {
    op_t               operation;
    logic              write_bit;
    logic [ValueW-1:0] entropy_word;
  } item_t;

  typedef struct packed {
    logic [ValueW-1:0] random_value;
    logic              ready_event;
    logic              irq_line;
    logic              ready_pulse;
    logic              running;
    logic              irq_enabled;
  } result_t;

  typedef struct packed {
    logic bias_correction;
    logic stop_on_ready;
  } cfg_t;

  function automatic logic [CountW-1:0] load_value(input logic first, input logic bias);
    logic [CountW:0] sum;
    logic [CountW:0] limit;
    limit = {1'b0, {CountW{1'b1}}};
    sum   = first ? (CountW+1)'(FIRST_EXTRA_DELAY) : '0;
    sum   = sum + (bias ? (CountW+1)'(CORRECTED_DELAY) : (CountW+1)'(RAW_DELAY));
    if (sum > limit) begin
      sum = limit;
    end
    return sum[CountW-1:0];
  endfunction

endpackage

>>> sv/rng_peripheral_ready_timer.sv
// Random number ready timer: one transaction (tick, task or register access)
// is accepted every clock cycle unless a stalled result blocks it. It is held in
// the item register, and its result is loaded into the result register, where
// it waits to be taken. The state update between the two registers is
// combinational, which allows that rate, and a stalled result holds both stages.
// Configuration: bias_correction at byte 0x0, stop_on_ready at 0x4 (bit 0).
// Depends on rngrt_pkg, rngrt_regs and rngrt_core.
module rng_peripheral_ready_timer
  import rngrt_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_ready,
  input  item_t               item,
  output logic                result_valid,
  input  logic                result_ready,
  output result_t             result,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CfgAddrW-1:0] paddr,
  input  logic [CfgDataW-1:0] pwdata,
  output logic [CfgDataW-1:0] prdata,
  output logic                pready
);

  cfg_t    cfg;
  item_t   stage;
  logic    stage_valid;
  logic    advance;
  logic    process;
  result_t result_next;

  assign advance    = !result_valid || result_ready;
  assign process    = stage_valid && advance;
  assign item_ready = !stage_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (item_ready) begin
      stage_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && item_ready) begin
      stage <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= stage_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (process) begin
      result <= result_next;
    end
  end

  rngrt_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  rngrt_core u_core (
    .clk         (clk),
    .rst         (rst),
    .process     (process),
    .item        (stage),
    .cfg         (cfg),
    .result_next (result_next)
  );

endmodule

>>> sv/rngrt_regs.sv
// APB configuration registers of the random number ready timer.
// Depends on rngrt_pkg.
module rngrt_regs
  import rngrt_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CfgAddrW-1:0] paddr,
  input  logic [CfgDataW-1:0] pwdata,
  output logic [CfgDataW-1:0] prdata,
  output logic                pready,
  output cfg_t                cfg
);

  logic     wr_en;
  reg_idx_t idx;
  logic     rd_bit;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = reg_idx_t'(paddr[2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr_en) begin
      case (idx)
        REG_BIAS_CORRECTION: cfg.bias_correction <= pwdata[0];
        REG_STOP_ON_READY:   cfg.stop_on_ready   <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_BIAS_CORRECTION: rd_bit = cfg.bias_correction;
      REG_STOP_ON_READY:   rd_bit = cfg.stop_on_ready;
      default:             rd_bit = 1'b0;
    endcase
  end

  assign prdata = {{(CfgDataW-1){1'b0}}, rd_bit};

endmodule

>>> sv/rngrt_core.sv
// Countdown, value register, event and enable state of the ready timer.
// Depends on rngrt_pkg.
module rngrt_core
  import rngrt_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    process,
  input  item_t   item,
  input  cfg_t    cfg,
  output result_t result_next
);

  logic              started_flag, started_flag_next;
  logic [CountW-1:0] ticks_left, ticks_left_next;
  logic              countdown_armed, countdown_armed_next;
  logic [ValueW-1:0] value_reg, value_reg_next;
  logic              event_flag, event_flag_next;
  logic              enable_bit, enable_bit_next;
  logic              pulse;

  always_comb begin
    started_flag_next    = started_flag;
    ticks_left_next      = ticks_left;
    countdown_armed_next = countdown_armed;
    value_reg_next       = value_reg;
    event_flag_next      = event_flag;
    enable_bit_next      = enable_bit;
    pulse                = 1'b0;
    case (item.operation)
      OP_TICK: begin
        if (countdown_armed) begin
          if (ticks_left <= CountW'(1)) begin
            value_reg_next  = item.entropy_word;
            ticks_left_next = load_value(1'b0, cfg.bias_correction);
            if (cfg.stop_on_ready) begin
              started_flag_next    = 1'b0;
              countdown_armed_next = 1'b0;
            end
            event_flag_next = 1'b1;
            pulse           = 1'b1;
          end else begin
            ticks_left_next = ticks_left - CountW'(1);
          end
        end
      end
      OP_START: begin
        if (!started_flag) begin
          started_flag_next    = 1'b1;
          ticks_left_next      = load_value(1'b1, cfg.bias_correction);
          countdown_armed_next = 1'b1;
        end
      end
      OP_STOP: begin
        started_flag_next    = 1'b0;
        countdown_armed_next = 1'b0;
      end
      OP_EN_SET: begin
        if (item.write_bit) begin
          enable_bit_next = 1'b1;
        end
      end
      OP_EN_CLR: begin
        if (item.write_bit) begin
          enable_bit_next = 1'b0;
        end
      end
      OP_EVT_WRITE: begin
        event_flag_next = item.write_bit;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      started_flag    <= 1'b0;
      ticks_left      <= '0;
      countdown_armed <= 1'b0;
      value_reg       <= '0;
      event_flag      <= 1'b0;
      enable_bit      <= 1'b0;
    end else if (process) begin
      started_flag    <= started_flag_next;
      ticks_left      <= ticks_left_next;
      countdown_armed <= countdown_armed_next;
      value_reg       <= value_reg_next;
      event_flag      <= event_flag_next;
      enable_bit      <= enable_bit_next;
    end
  end

  always_comb begin
    result_next.random_value = value_reg_next;
    result_next.ready_event  = event_flag_next;
    result_next.irq_line     = event_flag_next && enable_bit_next;
    result_next.ready_pulse  = pulse;
    result_next.running      = started_flag_next;
    result_next.irq_enabled  = enable_bit_next;
  end

  a_armed_tracks_running: assert property (@(posedge clk) disable iff (rst)
    countdown_armed == started_flag)
    else $error("countdown armed state differs from running flag");

  a_armed_count_nonzero: assert property (@(posedge clk) disable iff (rst)
    countdown_armed |-> (ticks_left != '0))
    else $error("armed countdown holds zero");

  a_stop_halts: assert property (@(posedge clk) disable iff (rst)
    (process && item.operation == OP_STOP) |=> (!started_flag && !countdown_armed))
    else $error("stop transaction left generator running");

endmodule

>>> dv/tb_rng_peripheral_ready_timer.sv
// Self-checking testbench for rng_peripheral_ready_timer: a directed table and
// phases of random transactions, checked against the table's expected results or else a cycle-free predictor.
// Depends on rngrt_pkg and the block's RTL.
module tb_rng_peripheral_ready_timer;
  timeunit 1ns;
  timeprecision 1ps;
  import rngrt_pkg::*;

  typedef struct packed {
    op_t                op;
    logic               wbit;
    logic [ValueW-1:0]  entropy;
    logic [7:0]         reps;
    logic               typed;
    result_t            want;
  } stim_row_t;

  localparam int unsigned NumRows = 21;
  localparam int unsigned NumPhases = 5;
  localparam int unsigned ItemsPerPhase = 340;

  localparam stim_row_t DIRECTED_PLAN [NumRows] = '{
    '{OP_TICK,       1'b0, 32'hFFFF_FFFF, 8'd1,   1'b1, '{32'h0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0}},
    '{op_t'(3'd6),   1'b1, 32'hFFFF_FFFF, 8'd1,   1'b1, '{32'h0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0}},
    '{op_t'(3'd7),   1'b1, 32'h0000_0000, 8'd1,   1'b1, '{32'h0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0}},
    '{OP_STOP,       1'b1, 32'hAAAA_5555, 8'd1,   1'b1, '{32'h0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0}},
    '{OP_EN_SET,     1'b0, 32'h5555_AAAA, 8'd1,   1'b1, '{32'h0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0}},
    '{OP_EN_SET,     1'b1, 32'h0000_0001, 8'd1,   1'b1, '{32'h0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1}},
    '{OP_EVT_WRITE,  1'b1, 32'h8000_0000, 8'd1,   1'b1, '{32'h0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1}},
    '{OP_EVT_WRITE,  1'b0, 32'h7FFF_FFFF, 8'd1,   1'b1, '{32'h0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1}},
    '{OP_EN_CLR,     1'b0, 32'h0000_0000, 8'd1,   1'b1, '{32'h0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1}},
    '{OP_EN_CLR,     1'b1, 32'hFFFF_FFFF, 8'd1,   1'b1, '{32'h0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0}},
    '{OP_START,      1'b0, 32'h1234_5678, 8'd1,   1'b1, '{32'h0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0}},
    '{OP_START,      1'b1, 32'h8765_4321, 8'd1,   1'b0, '0},
    '{OP_TICK,       1'b1, 32'hDEAD_BEEF, 8'd157, 1'b0, '0},
    '{OP_TICK,       1'b0, 32'hFFFF_FFFF, 8'd1,   1'b1,
      '{32'hFFFF_FFFF, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0}},
    '{OP_EN_SET,     1'b1, 32'h0F0F_0F0F, 8'd1,   1'b1,
      '{32'hFFFF_FFFF, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1}},
    '{OP_TICK,       1'b0, 32'h5A5A_A5A5, 8'd29,  1'b0, '0},
    '{OP_TICK,       1'b1, 32'h0000_0000, 8'd1,   1'b1, '{32'h0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1}},
    '{OP_STOP,       1'b0, 32'hC3C3_3C3C, 8'd1,   1'b1, '{32'h0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1}},
    '{OP_TICK,       1'b1, 32'hFFFF_0000, 8'd1,   1'b1, '{32'h0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1}},
    '{OP_EVT_WRITE,  1'b0, 32'h0000_FFFF, 8'd1,   1'b1, '{32'h0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1}},
    '{OP_EN_CLR,     1'b1, 32'h1357_9BDF, 8'd1,   1'b0, '0}
  };

  logic                clk;
  logic                rst;
  logic                item_valid;
  logic                item_ready;
  item_t               item;
  logic                result_valid;
  logic                result_ready;
  result_t             result;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [CfgAddrW-1:0] paddr;
  logic [CfgDataW-1:0] pwdata;
  logic [CfgDataW-1:0] prdata;
  logic                pready;

  rng_peripheral_ready_timer dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  logic              cfg_bias;
  logic              cfg_stop;
  logic              gen_started;
  logic [CountW-1:0] ticks_to_go;
  logic              armed;
  logic [ValueW-1:0] value_q;
  logic              event_q;
  logic              irq_en_q;

  result_t expected_results [$];
  int      mismatches = 0;
  logic    quiet_mode;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic logic [CountW-1:0] generation_delay(input logic first);
    int unsigned d;
    d = (first ? FIRST_EXTRA_DELAY : 0) + (cfg_bias ? CORRECTED_DELAY : RAW_DELAY);
    if (d > 255) begin
      d = 255;
    end
    return CountW'(d);
  endfunction

  function automatic result_t predict_rng_result(input item_t it);
    result_t r;
    logic    pulse;
    pulse = 1'b0;
    case (it.operation)
      OP_TICK: begin
        if (armed) begin
          if (ticks_to_go <= 1) begin
            value_q     = it.entropy_word;
            ticks_to_go = generation_delay(1'b0);
            armed       = 1'b1;
            if (cfg_stop) begin
              gen_started = 1'b0;
              armed       = 1'b0;
            end
            event_q = 1'b1;
            pulse   = 1'b1;
          end else begin
            ticks_to_go = ticks_to_go - 1'b1;
          end
        end
      end
      OP_START: begin
        if (!gen_started) begin
          gen_started = 1'b1;
          ticks_to_go = generation_delay(1'b1);
          armed       = 1'b1;
        end
      end
      OP_STOP: begin
        gen_started = 1'b0;
        armed       = 1'b0;
      end
      OP_EN_SET: begin
        if (it.write_bit) irq_en_q = 1'b1;
      end
      OP_EN_CLR: begin
        if (it.write_bit) irq_en_q = 1'b0;
      end
      OP_EVT_WRITE: begin
        event_q = it.write_bit;
      end
      default: begin
      end
    endcase
    r.random_value = value_q;
    r.ready_event  = event_q;
    r.irq_line     = event_q & irq_en_q;
    r.ready_pulse  = pulse;
    r.running      = gen_started;
    r.irq_enabled  = irq_en_q;
    return r;
  endfunction

  function automatic item_t random_item();
    item_t       it;
    int unsigned pick;
    pick = $urandom_range(0, 199);
    if (pick < 176)      it.operation = OP_TICK;
    else if (pick < 184) it.operation = OP_START;
    else if (pick < 185) it.operation = OP_STOP;
    else if (pick < 189) it.operation = OP_EN_SET;
    else if (pick < 193) it.operation = OP_EN_CLR;
    else if (pick < 197) it.operation = OP_EVT_WRITE;
    else if (pick < 199) it.operation = op_t'(3'd6);
    else                 it.operation = op_t'(3'd7);
    it.write_bit    = 1'($urandom_range(0, 1));
    it.entropy_word = $urandom;
    return it;
  endfunction

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      mismatches++;
    end
  endtask

  task automatic send_item(input item_t it, input result_t typed_want, input logic typed);
    int unsigned gap;
    result_t     predicted;
    gap = quiet_mode ? 0 : $urandom_range(0, 11);
    @(negedge clk);
    if (gap > 0) begin
      item_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    item       = it;
    item_valid = 1'b1;
    do @(posedge clk); while (!item_ready);
    predicted = predict_rng_result(it);
    expected_results.push_back(typed ? typed_want : predicted);
  endtask

  task automatic drain_results();
    @(negedge clk);
    item_valid = 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_register(input reg_idx_t idx, input logic bit_value);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = CfgAddrW'(4 * int'(idx));
    pwdata  = {31'($urandom_range(0, 32'h7FFF_FFFF)), bit_value};
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    if (idx == REG_BIAS_CORRECTION) cfg_bias = bit_value;
    else                            cfg_stop = bit_value;
  endtask

  initial begin
    int unsigned stall;
    result_ready = 1'b0;
    while (rst !== 1'b0) @(negedge clk);
    forever begin
      stall = quiet_mode ? 0 : $urandom_range(0, 11);
      @(negedge clk);
      if (stall > 0) begin
        result_ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      result_ready = 1'b1;
      do @(posedge clk); while (!result_valid);
      if (expected_results.size() == 0) begin
        $error("result arrived with no transaction outstanding");
        mismatches++;
      end else begin
        result_t want;
        want = expected_results.pop_front();
        compare_field("random_value", want.random_value, result.random_value);
        compare_field("ready_event", 32'(want.ready_event), 32'(result.ready_event));
        compare_field("irq_line", 32'(want.irq_line), 32'(result.irq_line));
        compare_field("ready_pulse", 32'(want.ready_pulse), 32'(result.ready_pulse));
        compare_field("running", 32'(want.running), 32'(result.running));
        compare_field("irq_enabled", 32'(want.irq_enabled), 32'(result.irq_enabled));
      end
    end
  end

  initial begin
    item_t     it;
    stim_row_t row;
    logic      phase_bias [NumPhases];
    logic      phase_stop [NumPhases];
    phase_bias = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
    phase_stop = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b0};
    rst         = 1'b1;
    item_valid  = 1'b0;
    item        = '0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    quiet_mode  = 1'b0;
    cfg_bias    = 1'b0;
    cfg_stop    = 1'b0;
    gen_started = 1'b0;
    ticks_to_go = '0;
    armed       = 1'b0;
    value_q     = '0;
    event_q     = 1'b0;
    irq_en_q    = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    for (int r = 0; r < NumRows; r++) begin
      row = DIRECTED_PLAN[r];
      it.operation    = row.op;
      it.write_bit    = row.wbit;
      it.entropy_word = row.entropy;
      for (int k = 0; k < int'(row.reps); k++) begin
        send_item(it, row.want, row.typed && (k == int'(row.reps) - 1));
      end
    end

    for (int p = 0; p < NumPhases; p++) begin
      drain_results();
      write_register(REG_BIAS_CORRECTION, phase_bias[p]);
      write_register(REG_STOP_ON_READY, phase_stop[p]);
      for (int n = 0; n < ItemsPerPhase; n++) begin
        if (n % 100 == 0) quiet_mode = ($urandom_range(0, 3) == 0);
        if ($urandom_range(0, 149) == 0) drain_results();
        send_item(random_item(), '0, 1'b0);
      end
    end

    drain_results();
    quiet_mode = 1'b0;
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #(2_000_000);
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
